// ----- design/cau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 24;

  // operation selector carried on in_tuser
  typedef enum logic [3:0] {
    ACT_ADD    = 4'd0,
    ACT_SUB    = 4'd1,
    ACT_MUL    = 4'd2,
    ACT_DIV    = 4'd3,
    ACT_SCALE  = 4'd4,
    ACT_DIVR   = 4'd5,
    ACT_NEG    = 4'd6,
    ACT_ABS2   = 4'd7,
    ACT_ABS    = 4'd8,
    ACT_SQUARE = 4'd9,
    ACT_PASS   = 4'd10
  } act_t;

  // result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  // control that travels along the divide / square root stages
  typedef struct packed {
    logic    iter;    // result comes from the iterative lanes
    logic    sqrt;    // lane re does square root steps
    logic    neg_re;  // sign of quotient re
    logic    neg_im;  // sign of quotient im
    logic    big_re;  // quotient re already known to overflow
    logic    big_im;  // quotient im already known to overflow
    status_t st;      // status of a direct result
  } step_ctl_t;

endpackage
`default_nettype wire

// ----- design/cau_mult.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cau_mult
  import cau_pkg::*;
#(
  parameter int unsigned W = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  act_t                  act,
  input  logic signed [W-1:0]   ar,
  input  logic signed [W-1:0]   ai,
  input  logic signed [W-1:0]   br,
  input  logic signed [W-1:0]   bi,
  output logic                  vld_r,
  output act_t                  act_r,
  output logic signed [W-1:0]   ar_r,
  output logic signed [W-1:0]   ai_r,
  output logic signed [W-1:0]   br_r,
  output logic signed [W-1:0]   bi_r,
  output logic signed [2*W-1:0] p0_r,
  output logic signed [2*W-1:0] p1_r,
  output logic signed [2*W-1:0] p2_r,
  output logic signed [2*W-1:0] p3_r,
  output logic signed [2*W-1:0] p4_r,
  output logic signed [2*W-1:0] p5_r
);

  logic                  sq;
  logic signed [W-1:0]   m0, m1, m2;
  logic signed [2*W-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt, p4_nxt, p5_nxt;

  // squaring actions multiply a by itself
  assign sq = (act == ACT_ABS2) || (act == ACT_ABS) || (act == ACT_SQUARE);
  assign m0 = sq ? ar : br;
  assign m1 = sq ? ai : bi;
  assign m2 = sq ? ar : br;

  assign p0_nxt = ar * m0;
  assign p1_nxt = ai * m1;
  assign p2_nxt = ai * m2;
  assign p3_nxt = ar * bi;
  assign p4_nxt = br * br;
  assign p5_nxt = bi * bi;

  // valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      act_r <= act;
      ar_r  <= ar;
      ai_r  <= ai;
      br_r  <= br;
      bi_r  <= bi;
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      p4_r  <= p4_nxt;
      p5_r  <= p5_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/cau_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cau_prep
  import cau_pkg::*;
#(
  parameter int unsigned W = WORD_BITS_DEF,
  parameter int unsigned F = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  act_t                  act,
  input  logic signed [W-1:0]   ar,
  input  logic signed [W-1:0]   ai,
  input  logic signed [W-1:0]   br,
  input  logic signed [W-1:0]   bi,
  input  logic signed [2*W-1:0] p0,
  input  logic signed [2*W-1:0] p1,
  input  logic signed [2*W-1:0] p2,
  input  logic signed [2*W-1:0] p3,
  input  logic signed [2*W-1:0] p4,
  input  logic signed [2*W-1:0] p5,
  output logic                  vld_r,
  output step_ctl_t             ctl_r,
  output logic [2*W+1:0]        r_re_r,
  output logic [2*W+1:0]        r_im_r,
  output logic [W-1:0]          q_re_r,
  output logic [W-1:0]          q_im_r,
  output logic [2*W-1:0]        src_re_r,
  output logic [2*W-1:0]        src_im_r,
  output logic [2*W:0]          den_r,
  output logic [W-1:0]          wd_re_r,
  output logic [W-1:0]          wd_im_r
);

  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned RW = 2 * W + 2;
  localparam int unsigned DW = 2 * W + 1;
  localparam int unsigned NW = SW + F;
  localparam int unsigned CW = NW - W + DW;
  localparam logic [W-1:0] POS_MAG = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};

  // ---------------- sum stage ----------------
  logic signed [SW-1:0] x_ar, x_ai, x_br, x_bi;
  logic signed [SW-1:0] x_p0, x_p1, x_p2, x_p3;
  logic signed [SW-1:0] re_s_nxt, im_s_nxt;
  logic [DW-1:0]        den_nxt;
  logic                 shf_nxt, dneg_nxt;
  logic [W-1:0]         br_mag;

  assign x_ar = SW'(ar);
  assign x_ai = SW'(ai);
  assign x_br = SW'(br);
  assign x_bi = SW'(bi);
  assign x_p0 = SW'(p0);
  assign x_p1 = SW'(p1);
  assign x_p2 = SW'(p2);
  assign x_p3 = SW'(p3);
  assign br_mag = br[W-1] ? (~br + 1'b1) : br;

  always_comb begin
    re_s_nxt = '0;
    im_s_nxt = '0;
    den_nxt  = '0;
    shf_nxt  = 1'b0;
    dneg_nxt = 1'b0;
    case (act)
      ACT_ADD: begin
        re_s_nxt = x_ar + x_br;
        im_s_nxt = x_ai + x_bi;
      end
      ACT_SUB: begin
        re_s_nxt = x_ar - x_br;
        im_s_nxt = x_ai - x_bi;
      end
      ACT_MUL: begin
        re_s_nxt = x_p0 - x_p1;
        im_s_nxt = x_p2 + x_p3;
        shf_nxt  = 1'b1;
      end
      ACT_DIV: begin
        re_s_nxt = x_p0 + x_p1;
        im_s_nxt = x_p2 - x_p3;
        den_nxt  = DW'(unsigned'(p4)) + DW'(unsigned'(p5));
      end
      ACT_SCALE: begin
        re_s_nxt = x_p0;
        im_s_nxt = x_p2;
        shf_nxt  = 1'b1;
      end
      ACT_DIVR: begin
        re_s_nxt = x_ar;
        im_s_nxt = x_ai;
        den_nxt  = DW'(br_mag);
        dneg_nxt = br[W-1];
      end
      ACT_NEG: begin
        re_s_nxt = -x_ar;
        im_s_nxt = -x_ai;
      end
      ACT_ABS2: begin
        re_s_nxt = x_p0 + x_p1;
        shf_nxt  = 1'b1;
      end
      ACT_ABS: begin
        re_s_nxt = x_p0 + x_p1;
      end
      ACT_SQUARE: begin
        re_s_nxt = x_p0 - x_p1;
        im_s_nxt = x_p2 + x_p2;
        shf_nxt  = 1'b1;
      end
      ACT_PASS: begin
        re_s_nxt = x_ar;
        im_s_nxt = x_ai;
      end
      default: begin
        re_s_nxt = '0;
      end
    endcase
  end

  logic                 s2_vld_r;
  act_t                 s2_act_r;
  logic signed [SW-1:0] re_s_r, im_s_r;
  logic [DW-1:0]        s2_den_r;
  logic                 shf_r, dneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_act_r <= act;
      re_s_r   <= re_s_nxt;
      im_s_r   <= im_s_nxt;
      s2_den_r <= den_nxt;
      shf_r    <= shf_nxt;
      dneg_r   <= dneg_nxt;
    end
  end

  // ---------------- truncate / saturate / divider setup ----------------
  logic          neg_re, neg_im;
  logic [SW-1:0] mag_re, mag_im, t_re, t_im;
  logic [W-1:0]  lim_re, lim_im, tc_re, tc_im;
  logic          sat_re, sat_im;
  logic [NW-1:0] n_re, n_im;
  logic [NW-W-1:0] r0_re, r0_im;
  logic          big_re, big_im;
  logic          is_div, is_sqrt, divz;
  step_ctl_t     ctl_nxt;
  logic [RW-1:0] r_re_nxt, r_im_nxt;
  logic [2*W-1:0] src_re_nxt, src_im_nxt;
  logic [W-1:0]  wd_re_nxt, wd_im_nxt;

  assign neg_re = re_s_r[SW-1];
  assign neg_im = im_s_r[SW-1];
  assign mag_re = neg_re ? unsigned'(-re_s_r) : unsigned'(re_s_r);
  assign mag_im = neg_im ? unsigned'(-im_s_r) : unsigned'(im_s_r);

  // truncation toward zero works on the magnitude
  assign t_re   = shf_r ? (mag_re >> F) : mag_re;
  assign t_im   = shf_r ? (mag_im >> F) : mag_im;
  assign lim_re = neg_re ? NEG_MAG : POS_MAG;
  assign lim_im = neg_im ? NEG_MAG : POS_MAG;
  assign sat_re = t_re > SW'(lim_re);
  assign sat_im = t_im > SW'(lim_im);
  assign tc_re  = sat_re ? lim_re : t_re[W-1:0];
  assign tc_im  = sat_im ? lim_im : t_im[W-1:0];

  assign is_div  = (s2_act_r == ACT_DIV) || (s2_act_r == ACT_DIVR);
  assign is_sqrt = (s2_act_r == ACT_ABS);
  assign divz    = is_div && (s2_den_r == '0);

  // dividend scaled by the fraction bits; quotient overflows the word
  // when its upper part already reaches the divisor
  assign n_re   = {mag_re, {F{1'b0}}};
  assign n_im   = {mag_im, {F{1'b0}}};
  assign r0_re  = n_re[NW-1:W];
  assign r0_im  = n_im[NW-1:W];
  assign big_re = CW'(r0_re) >= CW'(s2_den_r);
  assign big_im = CW'(r0_im) >= CW'(s2_den_r);

  always_comb begin
    ctl_nxt        = '0;
    r_re_nxt       = '0;
    r_im_nxt       = '0;
    src_re_nxt     = '0;
    src_im_nxt     = '0;
    wd_re_nxt      = '0;
    wd_im_nxt      = '0;
    ctl_nxt.st     = ST_OK;
    if (divz) begin
      ctl_nxt.st = ST_DIVZ;
    end else if (is_div) begin
      ctl_nxt.iter   = 1'b1;
      ctl_nxt.neg_re = neg_re ^ dneg_r;
      ctl_nxt.neg_im = neg_im ^ dneg_r;
      ctl_nxt.big_re = big_re;
      ctl_nxt.big_im = big_im;
      r_re_nxt       = big_re ? '0 : RW'(r0_re);
      r_im_nxt       = big_im ? '0 : RW'(r0_im);
      src_re_nxt     = {n_re[W-1:0], {W{1'b0}}};
      src_im_nxt     = {n_im[W-1:0], {W{1'b0}}};
    end else if (is_sqrt) begin
      ctl_nxt.iter = 1'b1;
      ctl_nxt.sqrt = 1'b1;
      src_re_nxt   = mag_re[2*W-1:0];
    end else begin
      wd_re_nxt  = neg_re ? (~tc_re + 1'b1) : tc_re;
      wd_im_nxt  = neg_im ? (~tc_im + 1'b1) : tc_im;
      ctl_nxt.st = (sat_re || sat_im) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r    <= ctl_nxt;
      r_re_r   <= r_re_nxt;
      r_im_r   <= r_im_nxt;
      q_re_r   <= '0;
      q_im_r   <= '0;
      src_re_r <= src_re_nxt;
      src_im_r <= src_im_nxt;
      den_r    <= s2_den_r;
      wd_re_r  <= wd_re_nxt;
      wd_im_r  <= wd_im_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/cau_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cau_step
  import cau_pkg::*;
#(
  parameter int unsigned W = WORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  step_ctl_t       ctl,
  input  logic [2*W+1:0]  r_re,
  input  logic [2*W+1:0]  r_im,
  input  logic [W-1:0]    q_re,
  input  logic [W-1:0]    q_im,
  input  logic [2*W-1:0]  src_re,
  input  logic [2*W-1:0]  src_im,
  input  logic [2*W:0]    den,
  input  logic [W-1:0]    wd_re,
  input  logic [W-1:0]    wd_im,
  output logic            vld_r,
  output step_ctl_t       ctl_r,
  output logic [2*W+1:0]  r_re_r,
  output logic [2*W+1:0]  r_im_r,
  output logic [W-1:0]    q_re_r,
  output logic [W-1:0]    q_im_r,
  output logic [2*W-1:0]  src_re_r,
  output logic [2*W-1:0]  src_im_r,
  output logic [2*W:0]    den_r,
  output logic [W-1:0]    wd_re_r,
  output logic [W-1:0]    wd_im_r
);

  localparam int unsigned RW = 2 * W + 2;

  // one quotient bit (divide) or one root bit (square root) per stage
  logic [RW-1:0]  sh_re, sh_im, sub_re, sub_im;
  logic           ge_re, ge_im;
  logic [RW-1:0]  r_re_nxt, r_im_nxt;
  logic [W-1:0]   q_re_nxt, q_im_nxt;
  logic [2*W-1:0] src_re_nxt, src_im_nxt;

  // lane re: divide or square root
  assign sh_re  = ctl.sqrt ? {r_re[RW-3:0], src_re[2*W-1:2*W-2]}
                           : {r_re[RW-2:0], src_re[2*W-1]};
  assign sub_re = ctl.sqrt ? RW'({q_re, 2'b01}) : RW'(den);
  assign ge_re  = sh_re >= sub_re;
  assign r_re_nxt   = ge_re ? (sh_re - sub_re) : sh_re;
  assign q_re_nxt   = {q_re[W-2:0], ge_re};
  assign src_re_nxt = ctl.sqrt ? {src_re[2*W-3:0], 2'b00} : {src_re[2*W-2:0], 1'b0};

  // lane im: divide only
  assign sh_im  = {r_im[RW-2:0], src_im[2*W-1]};
  assign sub_im = RW'(den);
  assign ge_im  = sh_im >= sub_im;
  assign r_im_nxt   = ge_im ? (sh_im - sub_im) : sh_im;
  assign q_im_nxt   = {q_im[W-2:0], ge_im};
  assign src_im_nxt = {src_im[2*W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r    <= ctl;
      r_re_r   <= r_re_nxt;
      r_im_r   <= r_im_nxt;
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
      src_re_r <= src_re_nxt;
      src_im_r <= src_im_nxt;
      den_r    <= den;
      wd_re_r  <= wd_re;
      wd_im_r  <= wd_im;
    end
  end

endmodule
`default_nettype wire

// ----- design/complex_arithmetic_unit_top.sv -----
// Complex arithmetic unit, signed fixed point (WORD_BITS-bit words with FRAC_BITS
// fraction bits). Each input transfer carries the action on in_tuser and the
// operands a and b on in_tdata; each produces exactly one result transfer, in
// order. One transfer per clock is accepted while the skid register is empty;
// every action passes the same stages (multiply, sum, setup, one stage per quotient
// or root bit of the divide / square root lanes, output register). The divide and
// square root lanes are fully pipelined, one bit per stage, and set the latency.
// Products and quotients are truncated toward zero, overflow saturates with
// status 1, a zero divisor gives a zero result with status 2.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit_top
  import cau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // a_re, a_im, b_re, b_im
  input  logic [((4*WORD_BITS+7)/8)*8-1:0]       in_tdata,
  // action
  input  logic [3:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // res_re, res_im
  output logic [((2*WORD_BITS+7)/8)*8-1:0]       out_tdata,
  // status
  output logic [1:0]                             out_tuser
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned RW = 2 * W + 2;
  localparam int unsigned OUT_DATA_W = ((2 * W + 7) / 8) * 8;
  localparam logic [W-1:0] POS_MAG = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};

  logic adv;
  logic out_vld_r, skid_vld_r;

  // whole pipeline moves unless the skid register is occupied
  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  // ---------------- multiply stage ----------------
  logic                  m_vld;
  act_t                  m_act;
  logic signed [W-1:0]   m_ar, m_ai, m_br, m_bi;
  logic signed [2*W-1:0] p0, p1, p2, p3, p4, p5;

  cau_mult #(.W(W)) u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_tvalid),
    .act    (act_t'(in_tuser)),
    .ar     (in_tdata[W-1:0]),
    .ai     (in_tdata[2*W-1:W]),
    .br     (in_tdata[3*W-1:2*W]),
    .bi     (in_tdata[4*W-1:3*W]),
    .vld_r  (m_vld),
    .act_r  (m_act),
    .ar_r   (m_ar),
    .ai_r   (m_ai),
    .br_r   (m_br),
    .bi_r   (m_bi),
    .p0_r   (p0),
    .p1_r   (p1),
    .p2_r   (p2),
    .p3_r   (p3),
    .p4_r   (p4),
    .p5_r   (p5)
  );

  // ---------------- sum and setup stages, then the bit stages ----------------
  logic [W:0]     vld_a;
  step_ctl_t      ctl_a    [0:W];
  logic [RW-1:0]  r_re_a   [0:W];
  logic [RW-1:0]  r_im_a   [0:W];
  logic [W-1:0]   q_re_a   [0:W];
  logic [W-1:0]   q_im_a   [0:W];
  logic [2*W-1:0] src_re_a [0:W];
  logic [2*W-1:0] src_im_a [0:W];
  logic [2*W:0]   den_a    [0:W];
  logic [W-1:0]   wd_re_a  [0:W];
  logic [W-1:0]   wd_im_a  [0:W];

  cau_prep #(.W(W), .F(FRAC_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (m_vld),
    .act      (m_act),
    .ar       (m_ar),
    .ai       (m_ai),
    .br       (m_br),
    .bi       (m_bi),
    .p0       (p0),
    .p1       (p1),
    .p2       (p2),
    .p3       (p3),
    .p4       (p4),
    .p5       (p5),
    .vld_r    (vld_a[0]),
    .ctl_r    (ctl_a[0]),
    .r_re_r   (r_re_a[0]),
    .r_im_r   (r_im_a[0]),
    .q_re_r   (q_re_a[0]),
    .q_im_r   (q_im_a[0]),
    .src_re_r (src_re_a[0]),
    .src_im_r (src_im_a[0]),
    .den_r    (den_a[0]),
    .wd_re_r  (wd_re_a[0]),
    .wd_im_r  (wd_im_a[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_step
    cau_step #(.W(W)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (vld_a[k]),
      .ctl      (ctl_a[k]),
      .r_re     (r_re_a[k]),
      .r_im     (r_im_a[k]),
      .q_re     (q_re_a[k]),
      .q_im     (q_im_a[k]),
      .src_re   (src_re_a[k]),
      .src_im   (src_im_a[k]),
      .den      (den_a[k]),
      .wd_re    (wd_re_a[k]),
      .wd_im    (wd_im_a[k]),
      .vld_r    (vld_a[k+1]),
      .ctl_r    (ctl_a[k+1]),
      .r_re_r   (r_re_a[k+1]),
      .r_im_r   (r_im_a[k+1]),
      .q_re_r   (q_re_a[k+1]),
      .q_im_r   (q_im_a[k+1]),
      .src_re_r (src_re_a[k+1]),
      .src_im_r (src_im_a[k+1]),
      .den_r    (den_a[k+1]),
      .wd_re_r  (wd_re_a[k+1]),
      .wd_im_r  (wd_im_a[k+1])
    );
  end

  // ---------------- final saturation and select ----------------
  step_ctl_t    fc;
  logic [W-1:0] fq_re, fq_im, flim_re, flim_im, fv_re, fv_im;
  logic         fsat_re, fsat_im;
  logic [W-1:0] res_re, res_im;
  status_t      res_st;

  assign fc      = ctl_a[W];
  assign fq_re   = q_re_a[W];
  assign fq_im   = q_im_a[W];
  assign flim_re = fc.neg_re ? NEG_MAG : POS_MAG;
  assign flim_im = fc.neg_im ? NEG_MAG : POS_MAG;
  assign fsat_re = fc.big_re || (fq_re > flim_re);
  assign fsat_im = fc.big_im || (fq_im > flim_im);
  assign fv_re   = fsat_re ? flim_re : fq_re;
  assign fv_im   = fsat_im ? flim_im : fq_im;

  always_comb begin
    if (fc.iter) begin
      res_re = fc.neg_re ? (~fv_re + 1'b1) : fv_re;
      if (fc.sqrt) begin
        res_im = '0;
        res_st = fsat_re ? ST_SAT : ST_OK;
      end else begin
        res_im = fc.neg_im ? (~fv_im + 1'b1) : fv_im;
        res_st = (fsat_re || fsat_im) ? ST_SAT : ST_OK;
      end
    end else begin
      res_re = wd_re_a[W];
      res_im = wd_im_a[W];
      res_st = fc.st;
    end
  end

  // ---------------- output register with skid ----------------
  logic         take;
  logic [W-1:0] out_re_r, out_im_r, sk_re_r, sk_im_r;
  status_t      out_st_r, sk_st_r;
  logic         load_out, load_skid, move_skid;

  assign take      = adv && vld_a[W];
  assign move_skid = skid_vld_r && out_tready;
  assign load_out  = take && (!out_vld_r || out_tready);
  assign load_skid = take && out_vld_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (take) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= load_skid;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      out_re_r <= sk_re_r;
      out_im_r <= sk_im_r;
      out_st_r <= sk_st_r;
    end else if (load_out) begin
      out_re_r <= res_re;
      out_im_r <= res_im;
      out_st_r <= res_st;
    end
    if (load_skid) begin
      sk_re_r <= res_re;
      sk_im_r <= res_im;
      sk_st_r <= res_st;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'({out_im_r, out_re_r});
  assign out_tuser  = out_st_r;

endmodule
`default_nettype wire

// ----- design/cau_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cau_checker
  import cau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   in_tvalid,
  input wire logic                                   in_tready,
  input wire logic                                   out_tvalid,
  input wire logic                                   out_tready,
  input wire logic [((2*WORD_BITS+7)/8)*8-1:0]       out_tdata,
  input wire logic [1:0]                             out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no status code beyond divide by zero
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_SAT) || (out_tuser == ST_DIVZ))
    else $error("undefined status");

  // divide by zero gives a zero result
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_DIVZ) |-> out_tdata == '0)
    else $error("nonzero result on divide by zero");

  // input is held off only while a result waits at the output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind complex_arithmetic_unit_top cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
